// ----- design/rmmq_pkg.sv -----
package rmmq_pkg;

   // Fixed field widths of the channels and the configuration register.
   localparam int INDEX_W = 10;
   localparam int FIELD_W = 32;
   localparam int COUNT_W = 11;

   // Defaults for the top-level parameters.
   localparam int LEAVES_DEFAULT = 1024;
   localparam int VALUE_BITS_DEFAULT = 32;

   // Reset value of the element count register.
   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

   // Operation codes carried by the func field.
   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD_LEAF,
      ST_UPD_LEVEL,
      ST_WALK,
      ST_COMBINE,
      ST_RESULT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic accept;
      logic upd_leaf;
      logic upd_level;
      logic walk;
      logic combine;
      logic load_rsp;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic write_ok;
      logic parent_is_root;
      logic walk_done;
   } dp_status_type;

endpackage

// ----- design/rmmq_ctrl.sv -----
module rmmq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_func,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rmmq_pkg::dp_cmd_type   cmd,
   input  rmmq_pkg::dp_status_type status
);
   import rmmq_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      rsp_free;

   // The output register can take a new result when empty or being emptied.
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_func == FUNC_QUERY) begin
                  state_in = ST_WALK;
               end else if (status.write_ok) begin
                  state_in = ST_UPD_LEAF;
               end
            end
         end
         ST_UPD_LEAF: begin
            state_in = ST_UPD_LEVEL;
         end
         ST_UPD_LEVEL: begin
            if (status.parent_is_root) state_in = ST_IDLE;
         end
         ST_WALK: begin
            if (status.walk_done) state_in = ST_COMBINE;
         end
         ST_COMBINE: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.accept = req_valid;
         end
         ST_UPD_LEAF: begin
            cmd.upd_leaf = 1'b1;
         end
         ST_UPD_LEVEL: begin
            cmd.upd_level = 1'b1;
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
         end
         ST_COMBINE: begin
            cmd.combine = 1'b1;
         end
         ST_RESULT: begin
            cmd.load_rsp = rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // Result valid: set on load, dropped once the transaction is taken.
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- design/rmmq_dp.sv -----
module rmmq_dp #(
   parameter int LEAVES     = rmmq_pkg::LEAVES_DEFAULT,
   parameter int VALUE_BITS = rmmq_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rmmq_pkg::dp_cmd_type                 cmd,
   output rmmq_pkg::dp_status_type              status,
   input  logic                                 csr_write_enable,
   input  logic [rmmq_pkg::COUNT_W-1:0]         csr_write_data,
   input  logic [rmmq_pkg::INDEX_W-1:0]         req_element_index,
   input  logic signed [rmmq_pkg::FIELD_W-1:0]  req_element_value,
   input  logic [rmmq_pkg::INDEX_W-1:0]         req_range_first,
   input  logic [rmmq_pkg::INDEX_W-1:0]         req_range_last,
   output logic signed [rmmq_pkg::FIELD_W-1:0]  rsp_range_max,
   output logic signed [rmmq_pkg::FIELD_W-1:0]  rsp_range_min,
   output logic [rmmq_pkg::FIELD_W-1:0]         rsp_range_spread,
   output logic                                 rsp_range_empty
);
   import rmmq_pkg::*;

   localparam int NODES = 2 * LEAVES;
   localparam int AW    = $clog2(NODES);
   localparam int CW    = $clog2(NODES + 1);
   localparam int VB    = VALUE_BITS;

   localparam logic signed [VB-1:0] MOST_NEG = {1'b1, {(VB-1){1'b0}}};
   localparam logic signed [VB-1:0] MOST_POS = {1'b0, {(VB-1){1'b1}}};

   // Tree storage: each word holds the node maximum above the node minimum.
   logic [2*VB-1:0] mem [NODES];

   logic [COUNT_W-1:0]     count_ff;
   logic [AW-1:0]          clr_ff;
   logic [AW-1:0]          node_ff;
   logic [AW-1:0]          node_in;
   logic signed [VB-1:0]   cur_max_ff;
   logic signed [VB-1:0]   cur_min_ff;
   logic [CW-1:0]          lo_ff;
   logic [CW-1:0]          hi_ff;
   logic [CW-1:0]          lo_in;
   logic [CW-1:0]          hi_in;
   logic                   empty_ff;
   logic                   empty_in;
   logic                   take_a_ff;
   logic                   take_b_ff;
   logic                   live;
   logic [2*VB-1:0]        rd_a_ff;
   logic [2*VB-1:0]        rd_b_ff;
   logic [AW-1:0]          addr_a;
   logic [AW-1:0]          addr_b;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [2*VB-1:0]        wr_data;
   logic signed [VB-1:0]   val_in;
   logic signed [VB-1:0]   sib_max;
   logic signed [VB-1:0]   sib_min;
   logic signed [VB-1:0]   par_max;
   logic signed [VB-1:0]   par_min;
   logic signed [VB-1:0]   rd_a_max;
   logic signed [VB-1:0]   rd_a_min;
   logic signed [VB-1:0]   rd_b_max;
   logic signed [VB-1:0]   rd_b_min;
   logic signed [VB-1:0]   acc_lo_max_ff;
   logic signed [VB-1:0]   acc_lo_min_ff;
   logic signed [VB-1:0]   acc_hi_max_ff;
   logic signed [VB-1:0]   acc_hi_min_ff;
   logic signed [VB-1:0]   res_max_ff;
   logic signed [VB-1:0]   res_min_ff;
   logic [VB:0]            diff;
   logic [FIELD_W-1:0]     spread_in;

   // The incoming element is taken as a VALUE_BITS two's complement number.
   assign val_in = VB'(req_element_value);

   // Query range check and the leaf bounds of the walk.
   always_comb begin
      empty_in = (req_range_first > req_range_last)
              || ({1'b0, req_range_last} >= count_ff)
              || (32'(req_range_last) >= 32'(LEAVES));
      lo_in = CW'(req_range_first) + CW'(LEAVES);
      if (empty_in) begin
         hi_in = lo_in;
      end else begin
         hi_in = CW'(req_range_last) + CW'(LEAVES) + CW'(1);
      end
      node_in = AW'(req_element_index) + AW'(LEAVES);
   end

   assign live = lo_ff < hi_ff;

   assign status.clear_last     = (clr_ff == AW'(NODES - 1));
   assign status.write_ok       = (32'(req_element_index) < 32'(LEAVES));
   assign status.parent_is_root = ((node_ff >> 1) == AW'(1));
   assign status.walk_done      = !live;

   // Split the registered read words into maximum and minimum halves.
   assign rd_a_max = $signed(rd_a_ff[2*VB-1:VB]);
   assign rd_a_min = $signed(rd_a_ff[VB-1:0]);
   assign rd_b_max = $signed(rd_b_ff[2*VB-1:VB]);
   assign rd_b_min = $signed(rd_b_ff[VB-1:0]);
   assign sib_max  = rd_a_max;
   assign sib_min  = rd_a_min;

   // Parent of the current path node from the node and its sibling.
   assign par_max = (cur_max_ff > sib_max) ? cur_max_ff : sib_max;
   assign par_min = (cur_min_ff < sib_min) ? cur_min_ff : sib_min;

   // Read addresses: sibling on an update, the two walk ends on a query.
   always_comb begin
      if (cmd.walk) begin
         addr_a = lo_ff[AW-1:0];
      end else if (cmd.upd_leaf) begin
         addr_a = node_ff ^ AW'(1);
      end else begin
         addr_a = (node_ff >> 1) ^ AW'(1);
      end
      addr_b = AW'(hi_ff - CW'(1));
   end

   // Write port: clearing pass, leaf store or parent refresh.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_ff;
      wr_data = {MOST_NEG, MOST_POS};
      if (cmd.clear) begin
         wr_en = 1'b1;
      end else if (cmd.upd_leaf) begin
         wr_en   = 1'b1;
         wr_addr = node_ff;
         wr_data = {cur_max_ff, cur_min_ff};
      end else if (cmd.upd_level) begin
         wr_en   = 1'b1;
         wr_addr = node_ff >> 1;
         wr_data = {par_max, par_min};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[addr_a];
      rd_b_ff <= mem[addr_b];
   end

   // Control registers: element count, sweep counter and read flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= COUNT_RESET;
         clr_ff    <= '0;
         take_a_ff <= 1'b0;
         take_b_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            count_ff <= csr_write_data;
         end
         if (cmd.clear) begin
            clr_ff <= clr_ff + AW'(1);
         end
         take_a_ff <= cmd.walk && live && lo_ff[0];
         take_b_ff <= cmd.walk && live && hi_ff[0];
      end
   end

   // Transaction registers: the update path and the query walk.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         node_ff       <= node_in;
         cur_max_ff    <= val_in;
         cur_min_ff    <= val_in;
         lo_ff         <= lo_in;
         hi_ff         <= hi_in;
         empty_ff      <= empty_in;
         acc_lo_max_ff <= MOST_NEG;
         acc_lo_min_ff <= MOST_POS;
         acc_hi_max_ff <= MOST_NEG;
         acc_hi_min_ff <= MOST_POS;
      end else begin
         if (cmd.upd_level) begin
            node_ff    <= node_ff >> 1;
            cur_max_ff <= par_max;
            cur_min_ff <= par_min;
         end
         if (cmd.walk && live) begin
            lo_ff <= CW'((lo_ff + CW'(lo_ff[0])) >> 1);
            hi_ff <= hi_ff >> 1;
         end
         // Each end of the walk keeps its own accumulators.
         if (take_a_ff) begin
            if (rd_a_max > acc_lo_max_ff) acc_lo_max_ff <= rd_a_max;
            if (rd_a_min < acc_lo_min_ff) acc_lo_min_ff <= rd_a_min;
         end
         if (take_b_ff) begin
            if (rd_b_max > acc_hi_max_ff) acc_hi_max_ff <= rd_b_max;
            if (rd_b_min < acc_hi_min_ff) acc_hi_min_ff <= rd_b_min;
         end
      end
   end

   // Merge the two ends of the walk.
   always_ff @(posedge clock) begin
      if (cmd.combine) begin
         res_max_ff <= (acc_lo_max_ff > acc_hi_max_ff) ? acc_lo_max_ff : acc_hi_max_ff;
         res_min_ff <= (acc_lo_min_ff < acc_hi_min_ff) ? acc_lo_min_ff : acc_hi_min_ff;
      end
   end

   // Spread is zero when no written element lies in the range.
   assign diff = {res_max_ff[VB-1], res_max_ff} - {res_min_ff[VB-1], res_min_ff};
   assign spread_in = (res_max_ff >= res_min_ff) ? FIELD_W'(diff) : '0;

   // Output register.
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_range_max    <= FIELD_W'(res_max_ff);
         rsp_range_min    <= FIELD_W'(res_min_ff);
         rsp_range_spread <= spread_in;
         rsp_range_empty  <= empty_ff;
      end
   end

endmodule

// ----- design/range_min_max_query_tree_top.sv -----
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   func, element index and value, range bounds
// rsp_      out        rsp_valid/rsp_stall   range max, min, spread, empty flag
// csr_      in         csr_write_enable      element count (11 bits)
//
// A write stores the leaf, then refreshes one tree level per cycle through the node
// memory's single write port, the sibling read overlapped.
// A query walks both ends of the range up the tree level by level, then merges the
// two ends and loads the output register.
// After reset a clearing pass writes every node before the first request is taken;
// reset is synchronous and active high.
// A stalled result sits in the output register while the next request is taken.
module range_min_max_query_tree_top #(
   parameter int LEAVES     = rmmq_pkg::LEAVES_DEFAULT,
   parameter int VALUE_BITS = rmmq_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_func,
   input  logic [rmmq_pkg::INDEX_W-1:0]         req_element_index,
   input  logic signed [rmmq_pkg::FIELD_W-1:0]  req_element_value,
   input  logic [rmmq_pkg::INDEX_W-1:0]         req_range_first,
   input  logic [rmmq_pkg::INDEX_W-1:0]         req_range_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [rmmq_pkg::FIELD_W-1:0]  rsp_range_max,
   output logic signed [rmmq_pkg::FIELD_W-1:0]  rsp_range_min,
   output logic [rmmq_pkg::FIELD_W-1:0]         rsp_range_spread,
   output logic                                 rsp_range_empty,
   input  logic                                 csr_write_enable,
   input  logic [rmmq_pkg::COUNT_W-1:0]         csr_write_data
);
   import rmmq_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencing of clear, update and query transactions.
   rmmq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Node memory, walk registers and result formatting.
   rmmq_dp #(
      .LEAVES     (LEAVES),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_element_index (req_element_index),
      .req_element_value (req_element_value),
      .req_range_first   (req_range_first),
      .req_range_last    (req_range_last),
      .rsp_range_max     (rsp_range_max),
      .rsp_range_min     (rsp_range_min),
      .rsp_range_spread  (rsp_range_spread),
      .rsp_range_empty   (rsp_range_empty)
   );

endmodule

// ----- test/tb_range_min_max_query_tree_top.sv -----
`timescale 1ns / 100ps

module tb_range_min_max_query_tree_top;
   import rmmq_pkg::*;

   localparam int TREE_LEAVES = LEAVES_DEFAULT;
   // Cycles allowed after the last result so that a trailing write can finish.
   localparam int SETTLE_CYCLES = 40;
   localparam int COUNT_RANDOM = -1;
   localparam int PHASES = 8;
   localparam int PHASE_COUNT [PHASES] = '{16, TREE_LEAVES, 0, 2047, 1, COUNT_RANDOM,
                                           TREE_LEAVES, 5};
   localparam int PHASE_ITEMS [PHASES] = '{200, 250, 60, 200, 80, 200, 250, 60};
   localparam logic signed [FIELD_W-1:0] VALUE_LOWEST  = {1'b1, {(FIELD_W-1){1'b0}}};
   localparam logic signed [FIELD_W-1:0] VALUE_HIGHEST = {1'b0, {(FIELD_W-1){1'b1}}};

   typedef struct {
      func_type            op;
      logic [INDEX_W-1:0]  index;
      logic [FIELD_W-1:0]  value;
      logic [INDEX_W-1:0]  first;
      logic [INDEX_W-1:0]  last;
   } tree_request_type;

   typedef struct {
      logic signed [FIELD_W-1:0] hi;
      logic signed [FIELD_W-1:0] lo;
      logic [FIELD_W-1:0]        spread;
      logic                      empty;
   } span_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_func = 1'b0;
   logic [INDEX_W-1:0]         req_element_index = '0;
   logic signed [FIELD_W-1:0]  req_element_value = '0;
   logic [INDEX_W-1:0]         req_range_first = '0;
   logic [INDEX_W-1:0]         req_range_last = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [FIELD_W-1:0]  rsp_range_max;
   logic signed [FIELD_W-1:0]  rsp_range_min;
   logic [FIELD_W-1:0]         rsp_range_spread;
   logic                       rsp_range_empty;
   logic                       csr_write_enable = 1'b0;
   logic [COUNT_W-1:0]         csr_write_data = '0;

   tree_request_type          pending_requests [$];
   span_result_type           span_results_due [$];
   logic signed [FIELD_W-1:0] tree_value [TREE_LEAVES];
   logic                      tree_written [TREE_LEAVES];
   logic [COUNT_W-1:0]        count_seen = COUNT_RESET;
   int                        count_setting = COUNT_RESET;
   logic                      req_taken = 1'b0;
   int                        idle_gap = 0;
   int                        burst_left = 0;
   int                        stall_left = 0;
   int                        calm_left = 0;
   int                        mismatches = 0;

   range_min_max_query_tree_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_element_index (req_element_index),
      .req_element_value (req_element_value),
      .req_range_first   (req_range_first),
      .req_range_last    (req_range_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_range_max     (rsp_range_max),
      .rsp_range_min     (rsp_range_min),
      .rsp_range_spread  (rsp_range_spread),
      .rsp_range_empty   (rsp_range_empty),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Mostly short pauses, now and then a long one.
   function automatic int pick_pause();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 15);
      return $urandom_range(30, 80);
   endfunction

   // Element values lean towards the extremes and small numbers so that ties occur.
   function automatic logic [FIELD_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return VALUE_LOWEST;
      if (roll == 1) return VALUE_HIGHEST;
      if (roll == 2) return $urandom_range(0, 20) - 10;
      return $urandom;
   endfunction

   // Range maximum, minimum and spread over the elements written so far.
   function automatic span_result_type predict_span(input logic [INDEX_W-1:0] first,
                                                    input logic [INDEX_W-1:0] last);
      span_result_type res;
      int limit;
      limit = (count_seen < TREE_LEAVES) ? count_seen : TREE_LEAVES;
      res.hi = VALUE_LOWEST;
      res.lo = VALUE_HIGHEST;
      res.spread = '0;
      res.empty = (first > last) || (last >= limit);
      if (!res.empty) begin
         for (int k = first; k <= last; k++) begin
            if (tree_written[k]) begin
               if (tree_value[k] > res.hi) res.hi = tree_value[k];
               if (tree_value[k] < res.lo) res.lo = tree_value[k];
            end
         end
         if (res.hi >= res.lo) res.spread = res.hi - res.lo;
      end
      return res;
   endfunction

   // Unused fields of each transaction carry random bits.
   task automatic push_write(input int idx, input logic [FIELD_W-1:0] val);
      tree_request_type item;
      item.op = FUNC_WRITE;
      item.index = INDEX_W'(idx);
      item.value = val;
      item.first = INDEX_W'($urandom);
      item.last = INDEX_W'($urandom);
      pending_requests.push_back(item);
   endtask

   task automatic push_query(input int first, input int last);
      tree_request_type item;
      item.op = FUNC_QUERY;
      item.index = INDEX_W'($urandom);
      item.value = $urandom;
      item.first = INDEX_W'(first);
      item.last = INDEX_W'(last);
      pending_requests.push_back(item);
   endtask

   // Holds the sender back until every transaction is through and every result is in.
   task automatic wait_until_quiet();
      @(posedge clock);
      while (pending_requests.size() != 0 || req_valid || span_results_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_element_count(input int count);
      wait_until_quiet();
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data = COUNT_W'(count);
      @(negedge clock);
      csr_write_enable = 1'b0;
      count_setting = count;
      @(posedge clock);
   endtask

   // Most queries fall inside the active count; the rest are arbitrary bounds.
   task automatic add_random_items(input int amount);
      int span;
      int last;
      span = (count_setting == 0 || count_setting > TREE_LEAVES) ? TREE_LEAVES : count_setting;
      for (int k = 0; k < amount; k++) begin
         if ($urandom_range(0, 1) == 0) begin
            push_write(($urandom_range(0, 9) < 8) ? $urandom_range(0, span - 1)
                                                  : $urandom_range(0, TREE_LEAVES - 1),
                       pick_value());
         end else if ($urandom_range(0, 3) != 0) begin
            last = $urandom_range(0, span - 1);
            if ($urandom_range(0, 2) == 0)
               push_query(last - $urandom_range(0, (last < 8) ? last : 8), last);
            else
               push_query($urandom_range(0, last), last);
         end else begin
            push_query($urandom_range(0, TREE_LEAVES - 1), $urandom_range(0, TREE_LEAVES - 1));
         end
      end
   endtask

   // Request driver: a stalled transaction is held, otherwise the next one follows a random, possibly empty, gap.
   always @(negedge clock) begin : request_driver
      tree_request_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (idle_gap != 0) begin
            req_valid <= 1'b0;
            idle_gap--;
         end else if (pending_requests.size() != 0) begin
            item = pending_requests.pop_front();
            req_func <= item.op;
            req_element_index <= item.index;
            req_element_value <= item.value;
            req_range_first <= item.first;
            req_range_last <= item.last;
            req_valid <= 1'b1;
            if (burst_left != 0) begin
               idle_gap = 0;
               burst_left--;
            end else begin
               idle_gap = pick_pause();
               if ($urandom_range(0, 29) == 0) burst_left = $urandom_range(20, 60);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result back-pressure, with occasional long stretches of none.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (calm_left != 0) begin
         rsp_stall <= 1'b0;
         calm_left--;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = pick_pause();
         calm_left = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(0, 3);
      end
   end

   // Monitor: checks each result against the oldest prediction, then records the
   // transaction and any register write seen at this edge.
   always @(posedge clock) begin : result_monitor
      span_result_type due;
      if (reset) begin
         count_seen = COUNT_RESET;
         req_taken = 1'b0;
         for (int k = 0; k < TREE_LEAVES; k++) tree_written[k] = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (span_results_due.size() == 0) begin
               $display("%0t: expected no result, got max %0d min %0d", $time, rsp_range_max,
                        rsp_range_min);
               mismatches++;
            end else begin
               due = span_results_due.pop_front();
               if (rsp_range_max !== due.hi) begin
                  $display("%0t: range_max expected %0d got %0d", $time, due.hi, rsp_range_max);
                  mismatches++;
               end
               if (rsp_range_min !== due.lo) begin
                  $display("%0t: range_min expected %0d got %0d", $time, due.lo, rsp_range_min);
                  mismatches++;
               end
               if (rsp_range_spread !== due.spread) begin
                  $display("%0t: range_spread expected %0d got %0d", $time, due.spread,
                           rsp_range_spread);
                  mismatches++;
               end
               if (rsp_range_empty !== due.empty) begin
                  $display("%0t: range_empty expected %0b got %0b", $time, due.empty,
                           rsp_range_empty);
                  mismatches++;
               end
            end
         end
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            if (req_func == FUNC_WRITE) begin
               tree_value[req_element_index] = req_element_value;
               tree_written[req_element_index] = 1'b1;
            end else begin
               span_results_due.push_back(predict_span(req_range_first, req_range_last));
            end
         end
         if (csr_write_enable) count_seen = csr_write_data;
      end
   end

   initial begin
      // With the reset count of one: an unwritten element, a range past the end and a
      // write beyond the count that must stay hidden.
      push_query(0, 0);
      push_query(0, 1);
      push_write(0, 42);
      push_write(700, -7);
      push_query(0, 0);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Full tree: extremes, duplicates, reversed and unwritten ranges.
      set_element_count(TREE_LEAVES);
      push_query(700, 700);
      push_write(TREE_LEAVES - 1, VALUE_HIGHEST);
      push_write(1, VALUE_LOWEST);
      push_write(5, -1);
      push_write(6, 0);
      push_write(7, -1);
      push_query(0, TREE_LEAVES - 1);
      push_query(10, 3);
      push_query(2, 4);
      push_query(TREE_LEAVES - 1, TREE_LEAVES - 1);
      push_query(5, 7);
      push_query(1, 1);
      push_query(8, 699);
      push_write(5, 100);
      push_query(5, 5);
      push_query(TREE_LEAVES - 2, TREE_LEAVES - 1);

      // One short of full: the last element falls outside.
      set_element_count(TREE_LEAVES - 1);
      push_query(0, TREE_LEAVES - 1);
      push_query(TREE_LEAVES - 1, TREE_LEAVES - 1);
      push_query(0, TREE_LEAVES - 2);

      for (int p = 0; p < PHASES; p++) begin
         set_element_count((PHASE_COUNT[p] == COUNT_RANDOM) ? $urandom_range(2, TREE_LEAVES - 1)
                                                            : PHASE_COUNT[p]);
         add_random_items(PHASE_ITEMS[p]);
      end

      wait_until_quiet();
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #12_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- range_min_max_query_tree_top.f -----
design/rmmq_pkg.sv
design/rmmq_ctrl.sv
design/rmmq_dp.sv
design/range_min_max_query_tree_top.sv
test/tb_range_min_max_query_tree_top.sv
